>>> hw/rtl/hill_cipher_3x3_mod27_encrypt_unit_assert.svh
// assertion macros for the hill cipher encrypt unit
// needs i_clk and i_rst_n in the scope of the module that uses them
`ifndef HILL_CIPHER_3X3_MOD27_ENCRYPT_UNIT_ASSERT_SVH
`define HILL_CIPHER_3X3_MOD27_ENCRYPT_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HCM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define HCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/hcm_pkg.sv
// shared types, constants and symbol helpers for the hill cipher encrypt unit
// no dependencies
package hcm_pkg;

    // symbol alphabet
    localparam int SYM_W     = 5;
    localparam int SYM_MOD   = 27;
    localparam int SYM_SPACE = 26;

    localparam logic [7:0] ASCII_A     = 8'h61;
    localparam logic [7:0] ASCII_Z     = 8'h7a;
    localparam logic [7:0] ASCII_SPACE = 8'h20;

    // key registers
    localparam int KEY_W = 3 * SYM_W;
    localparam logic [KEY_W-1:0] KEY_ROW0_RST = 15'd3137;
    localparam logic [KEY_W-1:0] KEY_ROW1_RST = 15'd6307;
    localparam logic [KEY_W-1:0] KEY_ROW2_RST = 15'd2217;

    typedef enum logic [1:0] {
        REG_KEY_ROW0 = 2'd0,
        REG_KEY_ROW1 = 2'd1,
        REG_KEY_ROW2 = 2'd2
    } t_reg_idx;

    typedef logic [2:0][KEY_W-1:0] t_key_set;

    // row arithmetic: sum of three 5x5 products, reduced mod 27
    localparam int ACC_W       = 12;
    localparam int RECIP       = 1213;   // floor(2^15 / 27)
    localparam int RECIP_W     = 11;
    localparam int RECIP_SHIFT = 15;
    localparam int QP_W        = ACC_W + RECIP_W;
    localparam int Q_W         = 7;

    // queues
    localparam int GQ_DEPTH = 4;
    localparam int GQ_AW    = $clog2(GQ_DEPTH);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    typedef logic [SYM_W-1:0] t_sym;

    typedef struct packed {
        t_sym [2:0] sym;
        logic       last;
    } t_group;

    typedef struct packed {
        logic   push;
        t_group grp;
    } t_gq_wr;

    // byte to symbol: a..z give 0..25, anything else the space symbol
    function automatic t_sym to_symbol(input logic [7:0] b);
        logic [7:0] d;
        d = b - ASCII_A;
        if (b >= ASCII_A && b <= ASCII_Z) begin
            return d[SYM_W-1:0];
        end
        return t_sym'(SYM_SPACE);
    endfunction

    // symbol to byte
    function automatic logic [7:0] to_byte(input t_sym s);
        if (s < t_sym'(SYM_SPACE)) begin
            return ASCII_A + {3'b000, s};
        end
        return ASCII_SPACE;
    endfunction

endpackage

>>> hw/rtl/hcm_front.sv
// front end: classifies bytes into symbols and assembles groups of three
// depends on hcm_pkg
module hcm_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            i_char_in,
    input  logic                  i_end_of_message,
    input  logic                  i_gq_full,
    output hcm_pkg::t_gq_wr       o_gq_wr
);

    logic [1:0]          r_fill;
    logic [1:0]          n_fill;
    hcm_pkg::t_sym [1:0] r_held;
    hcm_pkg::t_sym       w_sym;
    logic                w_accept;
    logic                w_close;
    hcm_pkg::t_group     w_grp;

    assign full     = i_gq_full;
    assign w_accept = push && !i_gq_full;
    assign w_sym    = hcm_pkg::to_symbol(i_char_in);
    assign w_close  = (r_fill == 2'd2) || i_end_of_message;

    // group as it stands with this beat, padded with spaces
    always_comb begin
        w_grp.sym[0] = (r_fill == 2'd0) ? w_sym : r_held[0];
        w_grp.sym[1] = (r_fill == 2'd1) ? w_sym :
                       (r_fill == 2'd2) ? r_held[1] :
                       hcm_pkg::t_sym'(hcm_pkg::SYM_SPACE);
        w_grp.sym[2] = (r_fill == 2'd2) ? w_sym :
                       hcm_pkg::t_sym'(hcm_pkg::SYM_SPACE);
        w_grp.last   = i_end_of_message;
    end

    assign o_gq_wr.push = w_accept && w_close;
    assign o_gq_wr.grp  = w_grp;

    // fill count
    always_comb begin
        n_fill = r_fill;
        if (w_accept) begin
            n_fill = w_close ? 2'd0 : r_fill + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // held symbols of the unfinished group
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_close) begin
            r_held[r_fill[0]] <= w_sym;
        end
    end

endmodule

>>> hw/rtl/hcm_grp_queue.sv
// short queue of complete groups between the front and back ends
// depends on hcm_pkg
module hcm_grp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hcm_pkg::t_gq_wr i_wr,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output hcm_pkg::t_group o_grp
);

    hcm_pkg::t_group [hcm_pkg::GQ_DEPTH-1:0] r_mem;
    logic [hcm_pkg::GQ_AW-1:0] r_wptr;
    logic [hcm_pkg::GQ_AW-1:0] r_rptr;
    logic [hcm_pkg::GQ_AW:0]   r_cnt;
    logic                      w_wr;
    logic                      w_rd;

    assign o_full  = (r_cnt == (hcm_pkg::GQ_AW+1)'(hcm_pkg::GQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_wr.push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_grp   = r_mem[r_rptr];

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + (hcm_pkg::GQ_AW+1)'(w_wr) - (hcm_pkg::GQ_AW+1)'(w_rd);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_wr.grp;
        end
    end

endmodule

>>> hw/rtl/hcm_back.sv
// back end: one key row per cycle unless stalled, a three-stage pipeline,
// mod 27 reduction by reciprocal multiply and the output queue; uses hcm_pkg
module hcm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hcm_pkg::t_key_set i_keys,
    input  logic              i_gq_empty,
    input  hcm_pkg::t_group   i_grp,
    output logic              o_gq_pop,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        o_char_out,
    output logic              o_last_out
);

    localparam int OQ_CW = hcm_pkg::OQ_AW + 2;

    logic [1:0]                     r_row;
    logic                           w_issue;
    logic [hcm_pkg::KEY_W-1:0]      w_key;
    logic [hcm_pkg::ACC_W-1:0]      w_acc;

    logic                           r_s1_vld;
    logic                           r_s1_last;
    logic [hcm_pkg::ACC_W-1:0]      r_s1_acc;

    logic [hcm_pkg::QP_W-1:0]       w_qprod;
    logic                           r_s2_vld;
    logic                           r_s2_last;
    logic [hcm_pkg::ACC_W-1:0]      r_s2_acc;
    logic [hcm_pkg::Q_W-1:0]        r_s2_q;

    logic [hcm_pkg::ACC_W-1:0]      w_q27;
    logic [hcm_pkg::ACC_W-1:0]      w_rem;
    logic [hcm_pkg::ACC_W-1:0]      w_rem_fix;
    logic [7:0]                     w_byte;

    logic [hcm_pkg::OQ_DEPTH-1:0][7:0] r_oq_char;
    logic [hcm_pkg::OQ_DEPTH-1:0]      r_oq_last;
    logic [hcm_pkg::OQ_AW-1:0]         r_oq_wptr;
    logic [hcm_pkg::OQ_AW-1:0]         r_oq_rptr;
    logic [hcm_pkg::OQ_AW:0]           r_oq_cnt;
    logic                              w_oq_rd;

    // issue a row while the output queue has room for everything in flight
    assign w_issue = !i_gq_empty &&
                     ((OQ_CW'(r_oq_cnt) + OQ_CW'(r_s1_vld) + OQ_CW'(r_s2_vld))
                      < OQ_CW'(hcm_pkg::OQ_DEPTH));
    assign o_gq_pop = w_issue && (r_row == 2'd2);
    assign w_key    = i_keys[r_row];

    // stage 1: dot product of key row and group
    assign w_acc = hcm_pkg::ACC_W'(w_key[4:0])   * hcm_pkg::ACC_W'(i_grp.sym[0])
                 + hcm_pkg::ACC_W'(w_key[9:5])   * hcm_pkg::ACC_W'(i_grp.sym[1])
                 + hcm_pkg::ACC_W'(w_key[14:10]) * hcm_pkg::ACC_W'(i_grp.sym[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= 2'd0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (w_issue) begin
                r_row <= (r_row == 2'd2) ? 2'd0 : r_row + 2'd1;
            end
            r_s1_vld <= w_issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_acc  <= w_acc;
        r_s1_last <= i_grp.last && (r_row == 2'd2);
    end

    // stage 2: quotient estimate, exact or one low
    assign w_qprod = hcm_pkg::QP_W'(r_s1_acc) * hcm_pkg::QP_W'(hcm_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        r_s2_acc  <= r_s1_acc;
        r_s2_q    <= w_qprod[hcm_pkg::RECIP_SHIFT +: hcm_pkg::Q_W];
        r_s2_last <= r_s1_last;
    end

    // stage 3: remainder with one correction step, then the cipher byte
    assign w_q27     = (hcm_pkg::ACC_W'(r_s2_q) << 5) - (hcm_pkg::ACC_W'(r_s2_q) << 2)
                     - hcm_pkg::ACC_W'(r_s2_q);
    assign w_rem     = r_s2_acc - w_q27;
    assign w_rem_fix = (w_rem >= hcm_pkg::ACC_W'(hcm_pkg::SYM_MOD))
                     ? w_rem - hcm_pkg::ACC_W'(hcm_pkg::SYM_MOD) : w_rem;
    assign w_byte    = hcm_pkg::to_byte(w_rem_fix[hcm_pkg::SYM_W-1:0]);

    // output queue
    assign empty      = (r_oq_cnt == '0);
    assign w_oq_rd    = pop && !empty;
    assign o_char_out = r_oq_char[r_oq_rptr];
    assign o_last_out = r_oq_last[r_oq_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wptr <= '0;
            r_oq_rptr <= '0;
            r_oq_cnt  <= '0;
        end else begin
            if (r_s2_vld) begin
                r_oq_wptr <= r_oq_wptr + 1'b1;
            end
            if (w_oq_rd) begin
                r_oq_rptr <= r_oq_rptr + 1'b1;
            end
            r_oq_cnt <= r_oq_cnt + (hcm_pkg::OQ_AW+1)'(r_s2_vld)
                      - (hcm_pkg::OQ_AW+1)'(w_oq_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_oq_char[r_oq_wptr] <= w_byte;
            r_oq_last[r_oq_wptr] <= r_s2_last;
        end
    end

endmodule

>>> hw/rtl/hill_cipher_3x3_mod27_encrypt_unit.sv
// Hill cipher encryptor, 3x3 key modulo 27, one message byte per beat.
//
// Input channel: a byte and an end-of-message flag are taken on a beat where
// push is high and full is low. Every third byte, or a byte flagged as the
// end of the message, closes a group of three symbols (short groups padded
// with spaces); the group goes to a four-entry group queue.
// Output channel: while empty is low the oldest cipher byte and its last flag
// are on the result ports; pop takes it. Three bytes come out per group, the
// third of a group closed by end of message carries last.
// Key rows are written through i_cfg_we / i_cfg_idx / i_cfg_data by the user
// only while idle; the block does not enforce it. Each key row of a group
// passes the stage 1 and 2 registers into the output queue. The back end does
// one key row per cycle while the output queue has room, so one byte per
// cycle is sustained on a full-group stream, but a one-byte message still
// takes three key rows. A stalled receiver fills the four-entry output queue,
// then the back end holds, then the group queue fills and full rises. Reset
// clears both queues and the group fill and loads the default key.
// depends on hcm_pkg, hcm_front, hcm_grp_queue, hcm_back and the assert header
`include "hill_cipher_3x3_mod27_encrypt_unit_assert.svh"

module hill_cipher_3x3_mod27_encrypt_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [hcm_pkg::KEY_W-1:0] i_cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic [7:0]                i_char_in,
    input  logic                      i_end_of_message,
    output logic                      empty,
    input  logic                      pop,
    output logic [7:0]                o_char_out,
    output logic                      o_last_out
);

    hcm_pkg::t_key_set r_keys;
    hcm_pkg::t_gq_wr   w_gq_wr;
    hcm_pkg::t_group   w_gq_grp;
    logic              w_gq_full;
    logic              w_gq_empty;
    logic              w_gq_pop;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys[0] <= hcm_pkg::KEY_ROW0_RST;
            r_keys[1] <= hcm_pkg::KEY_ROW1_RST;
            r_keys[2] <= hcm_pkg::KEY_ROW2_RST;
        end else if (i_cfg_we) begin
            unique case (hcm_pkg::t_reg_idx'(i_cfg_idx))
                hcm_pkg::REG_KEY_ROW0: r_keys[0] <= i_cfg_data;
                hcm_pkg::REG_KEY_ROW1: r_keys[1] <= i_cfg_data;
                hcm_pkg::REG_KEY_ROW2: r_keys[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hcm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_char_in        (i_char_in),
        .i_end_of_message (i_end_of_message),
        .i_gq_full        (w_gq_full),
        .o_gq_wr          (w_gq_wr)
    );

    hcm_grp_queue u_grp_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_gq_wr),
        .o_full  (w_gq_full),
        .i_pop   (w_gq_pop),
        .o_empty (w_gq_empty),
        .o_grp   (w_gq_grp)
    );

    hcm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_keys     (r_keys),
        .i_gq_empty (w_gq_empty),
        .i_grp      (w_gq_grp),
        .o_gq_pop   (w_gq_pop),
        .empty      (empty),
        .pop        (pop),
        .o_char_out (o_char_out),
        .o_last_out (o_last_out)
    );

    // an accepted end-of-message beat always closes a group
    `HCM_ASSERT_IMPL(a_eom_closes, push && !full && i_end_of_message, w_gq_wr.push, "eom beat did not close a group")
    // every waiting result is a letter or a space
    `HCM_ASSERT_IMPL(a_out_alphabet, !empty, o_char_out == hcm_pkg::ASCII_SPACE || (o_char_out >= hcm_pkg::ASCII_A && o_char_out <= hcm_pkg::ASCII_Z), "cipher byte outside alphabet")
    // a group accepted into an empty queue is visible on the next cycle
    `HCM_ASSERT_NEXT(a_gq_visible, w_gq_wr.push && !w_gq_full && w_gq_empty, !w_gq_empty, "closed group lost")

endmodule

>>> sim/cipher_stream_check.sv
`timescale 1ns / 100ps
// stream checker for the 3x3 mod-27 hill cipher encrypt unit
// watches the key port and both queue channels, predicts cipher beats and compares
// depends on hcm_pkg

module cipher_stream_check
    import hcm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [KEY_W-1:0] i_cfg_data,
    input  logic             i_push,
    input  logic             i_full,
    input  logic [7:0]       i_char_in,
    input  logic             i_end_of_message,
    input  logic             i_empty,
    input  logic             i_pop,
    input  logic [7:0]       i_char_out,
    input  logic             i_last_out,
    output int               o_fail_count,
    output int               o_due_beats,
    output int               o_bytes_in,
    output int               o_bytes_out
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_cipher_beat;

    t_cipher_beat     cipher_due[$];
    logic [KEY_W-1:0] key_row[3];
    t_sym             held_sym[2];
    int               group_fill;
    int               fail_count;
    int               report_count;
    int               bytes_in;
    int               bytes_out;

    // plaintext byte to alphabet symbol
    function automatic t_sym symbol_of(input logic [7:0] b);
        if (b >= ASCII_A && b <= ASCII_Z) begin
            return t_sym'(b - ASCII_A);
        end
        return t_sym'(SYM_SPACE);
    endfunction

    // alphabet symbol to cipher byte
    function automatic logic [7:0] cipher_byte(input int v);
        if (v < SYM_SPACE) begin
            return ASCII_A + 8'(v);
        end
        return ASCII_SPACE;
    endfunction

    // one key row times the group, reduced mod 27
    function automatic int row_mod(input logic [KEY_W-1:0] row, input t_sym a,
                                   input t_sym b, input t_sym c);
        int acc;
        acc = int'(row[4:0]) * int'(a) + int'(row[9:5]) * int'(b)
            + int'(row[14:10]) * int'(c);
        return acc % SYM_MOD;
    endfunction

    // note a failure, report only the first few
    task automatic log_fail(input string what, input t_cipher_beat want);
        fail_count++;
        if (report_count < 10) begin
            $display("%0t: cipher beat %0d %s: expected char %h last %b, got char %h last %b",
                     $realtime, bytes_out, what, want.ch, want.last, i_char_out, i_last_out);
        end
        report_count++;
    endtask

    always @(posedge i_clk) begin
        t_sym         sym;
        t_sym         grp[3];
        t_cipher_beat want;
        if (!i_rst_n) begin
            cipher_due.delete();
            key_row[0] = KEY_ROW0_RST;
            key_row[1] = KEY_ROW1_RST;
            key_row[2] = KEY_ROW2_RST;
            held_sym[0] = t_sym'(SYM_SPACE);
            held_sym[1] = t_sym'(SYM_SPACE);
            group_fill = 0;
            fail_count = 0;
            report_count = 0;
            bytes_in = 0;
            bytes_out = 0;
        end else begin
            // key writes, spare index ignored
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_KEY_ROW0: key_row[0] = i_cfg_data;
                    REG_KEY_ROW1: key_row[1] = i_cfg_data;
                    REG_KEY_ROW2: key_row[2] = i_cfg_data;
                    default: ;
                endcase
            end

            // output beat against the oldest prediction
            if (i_pop && !i_empty) begin
                if (cipher_due.size() == 0) begin
                    want = '0;
                    log_fail("with nothing due", want);
                end else begin
                    want = cipher_due.pop_front();
                    if (want.ch !== i_char_out || want.last !== i_last_out) begin
                        log_fail("mismatch", want);
                    end
                end
                bytes_out++;
            end

            // input beat: collect symbols, close group on third or on message end
            if (i_push && !i_full) begin
                sym = symbol_of(i_char_in);
                if (group_fill < 2 && !i_end_of_message) begin
                    held_sym[group_fill] = sym;
                    group_fill++;
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        grp[k] = (k < group_fill) ? held_sym[k] : t_sym'(SYM_SPACE);
                    end
                    grp[group_fill] = sym;
                    for (int r = 0; r < 3; r++) begin
                        want.ch = cipher_byte(row_mod(key_row[r], grp[0], grp[1], grp[2]));
                        want.last = i_end_of_message && (r == 2);
                        cipher_due.push_back(want);
                    end
                    group_fill = 0;
                end
                bytes_in++;
            end
        end
        o_fail_count <= fail_count;
        o_due_beats <= cipher_due.size();
        o_bytes_in <= bytes_in;
        o_bytes_out <= bytes_out;
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// top of the hill cipher encrypt unit testbench: clock, reset, key writes and stimulus
// depends on hcm_pkg, the encrypt unit and cipher_stream_check

module testbench;
    import hcm_pkg::*;

    localparam int          CYCLE_LIMIT     = 600000;
    localparam int          DRAIN_CYCLES    = 20;
    localparam int          BYTES_PER_PHASE = 80;
    localparam logic [1:0]  REG_SPARE       = 2'd3;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_idx = '0;
    logic [KEY_W-1:0] cfg_data = '0;
    logic             push = 1'b0;
    logic             full;
    logic [7:0]       char_in = '0;
    logic             end_of_message = 1'b0;
    logic             empty;
    logic             pop = 1'b0;
    logic [7:0]       char_out;
    logic             last_out;

    int               fail_count;
    int               due_beats;
    int               bytes_in;
    int               bytes_out;
    int               cycle_count = 0;
    int               pop_hold = 0;
    int               key_settings = 1;
    logic             idle_on = 1'b1;

    hill_cipher_3x3_mod27_encrypt_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .push             (push),
        .full             (full),
        .i_char_in        (char_in),
        .i_end_of_message (end_of_message),
        .empty            (empty),
        .pop              (pop),
        .o_char_out       (char_out),
        .o_last_out       (last_out)
    );

    cipher_stream_check u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_push           (push),
        .i_full           (full),
        .i_char_in        (char_in),
        .i_end_of_message (end_of_message),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_char_out       (char_out),
        .i_last_out       (last_out),
        .o_fail_count     (fail_count),
        .o_due_beats      (due_beats),
        .o_bytes_in       (bytes_in),
        .o_bytes_out      (bytes_out)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[hill_cipher_3x3_mod27_encrypt_unit] ERROR");
            $finish;
        end
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // receiver: pop with random stalls
    always @(posedge i_clk) begin
        if (pop_hold != 0) begin
            pop <= 1'b0;
            pop_hold--;
        end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                pop_hold = pick_gap();
            end
        end
    end

    // one input beat, waits for acceptance; push stays high across back-to-back beats
    task automatic send_byte(input logic [7:0] c, input logic eom);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        char_in <= c;
        end_of_message <= eom;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // stop sending and let every cipher beat come out
    task automatic drain_all();
        push <= 1'b0;
        @(posedge i_clk);
        while (due_beats != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // key port write, leaves the enable high for a following write
    task automatic write_reg(input logic [1:0] idx, input logic [KEY_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_key(input logic [KEY_W-1:0] r0, input logic [KEY_W-1:0] r1,
                            input logic [KEY_W-1:0] r2);
        write_reg(REG_KEY_ROW0, r0);
        write_reg(REG_KEY_ROW1, r1);
        write_reg(REG_KEY_ROW2, r2);
        cfg_we <= 1'b0;
        key_settings++;
    endtask

    // key row of three entries in lo..hi
    function automatic logic [KEY_W-1:0] rand_row(input int lo, input int hi);
        return {5'($urandom_range(lo, hi)), 5'($urandom_range(lo, hi)),
                5'($urandom_range(lo, hi))};
    endfunction

    // mostly lowercase messages of random length, each closed by message end
    task automatic send_messages(input int n);
        int         sent;
        int         len;
        int         r;
        logic [7:0] c;
        sent = 0;
        while (sent < n) begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 9) : $urandom_range(10, 40);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(0, 99);
                if (r < 82) begin
                    c = 8'($urandom_range(ASCII_A, ASCII_Z));
                end else if (r < 92) begin
                    c = ASCII_SPACE;
                end else begin
                    c = 8'($urandom_range(0, 255));
                end
                send_byte(c, i == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, default key: full groups, message end at each fill, byte extremes
        send_byte(ASCII_A, 1'b0);
        send_byte(ASCII_Z, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h79, 1'b1);
        send_byte(8'h60, 1'b1);
        send_byte(8'h7B, 1'b0);
        send_byte(ASCII_SPACE, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(ASCII_A, 1'b1);
        send_byte(ASCII_Z, 1'b0);
        send_byte(ASCII_Z, 1'b1);
        send_byte(8'h55, 1'b1);
        drain_all();

        // default key, random messages
        send_messages(BYTES_PER_PHASE);
        drain_all();

        // all entries 31, no idling on either side
        idle_on <= 1'b0;
        load_key({KEY_W{1'b1}}, {KEY_W{1'b1}}, {KEY_W{1'b1}});
        send_messages(BYTES_PER_PHASE);
        drain_all();

        // all-zero key
        idle_on <= 1'b1;
        load_key('0, '0, '0);
        send_messages(BYTES_PER_PHASE);
        drain_all();

        // spare index written, then a random key
        write_reg(REG_SPARE, {KEY_W{1'b1}});
        load_key(rand_row(0, 31), rand_row(0, 31), rand_row(0, 31));
        send_messages(BYTES_PER_PHASE);
        drain_all();

        // entries at or above the modulus
        load_key(rand_row(27, 31), rand_row(27, 31), rand_row(27, 31));
        send_messages(BYTES_PER_PHASE);
        drain_all();

        $display("run covered %0d plaintext bytes and %0d cipher bytes over %0d key settings",
                 bytes_in, bytes_out, key_settings);
        if (fail_count == 0) begin
            $display("[hill_cipher_3x3_mod27_encrypt_unit] OK");
        end else begin
            $display("%0d failures", fail_count);
            $display("[hill_cipher_3x3_mod27_encrypt_unit] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/hcm_pkg.sv
hw/rtl/hcm_front.sv
hw/rtl/hcm_grp_queue.sv
hw/rtl/hcm_back.sv
hw/rtl/hill_cipher_3x3_mod27_encrypt_unit.sv
sim/cipher_stream_check.sv
sim/testbench.sv
